[src/tdma_srt_pkg.sv]
// Shared types and constants for the TDMA slot reservation table.
package tdma_srt_pkg;

   localparam int SLOT_COUNT = 49;
   localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int SLOT_CNT_W = $clog2(SLOT_COUNT + 1);

   localparam logic [1:0] TYPE_REQUEST = 2'd0;
   localparam logic [1:0] TYPE_ACK     = 2'd1;
   localparam logic [1:0] TYPE_RELEASE = 2'd2;
   localparam logic [1:0] TYPE_EXPIRE  = 2'd3;

   localparam logic [1:0] CMD_MAINTAIN = 2'd0;
   localparam logic [1:0] CMD_ALLOCATE = 2'd1;
   localparam logic [1:0] CMD_RELEASE  = 2'd2;

   localparam logic [1:0] ACK_NOP     = 2'd0;
   localparam logic [1:0] ACK_APPROVE = 2'd1;
   localparam logic [1:0] ACK_DENIAL  = 2'd2;

   localparam logic [1:0] MODE_INVALID = 2'd0;
   localparam logic [1:0] MODE_RECV    = 2'd1;
   localparam logic [1:0] MODE_SEND    = 2'd2;

   localparam logic [2:0] KIND_VACANT      = 3'd0;
   localparam logic [2:0] KIND_PREORDAINED = 3'd1;

   typedef struct packed {
      logic [5:0] owner;
      logic [1:0] mode;
      logic [2:0] kind;
   } slot_entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_SCAN,
      ST_DONE
   } state_type;

endpackage

[src/tdma_slot_reservation_table_core.sv]
// TDMA slot reservation table: slot memory, sequencer and reply logic.
//
//   channel | ports                                        | direction
//   --------+----------------------------------------------+----------
//   req     | req_valid/req_ready, req_type .. req_ack_code | in
//   rsp     | rsp_valid/rsp_ready, rsp_reply_* , rsp_changed| out
//
// Request, ack and expire beats are accepted, evaluated and handed to the
// output register; evaluation is skipped when the slot is out of range. A
// release-neighbor beat walks the slot memory through its single read port,
// one slot a cycle. A new beat is accepted only in idle; a finished result
// waits in the output register while the next beat is taken. Synchronous
// reset clears the valid bit of every slot, so all entries read as vacant
// right away.
module tdma_slot_reservation_table_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_type,
   input  logic [5:0] req_slot,
   input  logic [5:0] req_peer_id,
   input  logic [1:0] req_command,
   input  logic [1:0] req_link_mode,
   input  logic [2:0] req_link_kind,
   input  logic [1:0] req_ack_code,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_reply_ack,
   output logic [5:0] rsp_reply_owner,
   output logic [1:0] rsp_reply_mode,
   output logic [2:0] rsp_reply_kind,
   output logic       rsp_changed
);

   localparam int IW = tdma_srt_pkg::SLOT_IDX_W;
   localparam int CW = tdma_srt_pkg::SLOT_CNT_W;

   tdma_srt_pkg::slot_entry_type mem [tdma_srt_pkg::SLOT_COUNT];
   tdma_srt_pkg::slot_entry_type rd_data_ff;

   tdma_srt_pkg::state_type state_ff, state_in;

   logic [tdma_srt_pkg::SLOT_COUNT-1:0] valid_ff, valid_in;
   logic [IW-1:0] addr_ff, addr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          pend_ff, pend_in;

   logic [1:0] type_ff, cmd_ff, mode_ff, ack_ff;
   logic [5:0] peer_ff;
   logic [2:0] kind_ff;

   logic [1:0] res_ack_ff, res_ack_in;
   logic [5:0] res_owner_ff, res_owner_in;
   logic [1:0] res_mode_ff, res_mode_in;
   logic [2:0] res_kind_ff, res_kind_in;
   logic       res_chg_ff, res_chg_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] out_ack_ff;
   logic [5:0] out_owner_ff;
   logic [1:0] out_mode_ff;
   logic [2:0] out_kind_ff;
   logic       out_chg_ff;

   logic                         accept;
   logic                         slot_ok;
   logic                         out_load;
   logic                         rd_en;
   logic [IW-1:0]                rd_addr;
   logic                         mem_we;
   tdma_srt_pkg::slot_entry_type mem_wdata;
   tdma_srt_pkg::slot_entry_type cur;
   logic                         owner_hit;
   logic                         scan_end;

   assign accept   = req_valid && req_ready;
   assign slot_ok  = {1'b0, req_slot} < 7'(tdma_srt_pkg::SLOT_COUNT);
   assign out_load = (state_ff == tdma_srt_pkg::ST_DONE) && (!rsp_valid_ff || rsp_ready);
   assign scan_end = (cnt_ff == CW'(tdma_srt_pkg::SLOT_COUNT)) && !pend_ff;

   // entry under evaluation; a slot never written since reset reads as zero
   assign cur       = valid_ff[addr_ff] ? rd_data_ff : '0;
   // the one owner compare, shared by single-slot items and the sweep
   assign owner_hit = (cur.owner == peer_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tdma_srt_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_type == tdma_srt_pkg::TYPE_RELEASE) begin
                  state_in = tdma_srt_pkg::ST_SCAN;
               end else if (slot_ok) begin
                  state_in = tdma_srt_pkg::ST_EVAL;
               end else begin
                  state_in = tdma_srt_pkg::ST_DONE;
               end
            end
         end
         tdma_srt_pkg::ST_EVAL: state_in = tdma_srt_pkg::ST_DONE;
         tdma_srt_pkg::ST_SCAN: begin
            if (scan_end) begin
               state_in = tdma_srt_pkg::ST_DONE;
            end
         end
         tdma_srt_pkg::ST_DONE: begin
            if (out_load) begin
               state_in = tdma_srt_pkg::ST_IDLE;
            end
         end
         default: state_in = tdma_srt_pkg::ST_IDLE;
      endcase
   end

   // datapath control and result
   always_comb begin
      req_ready    = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = req_slot[IW-1:0];
      addr_in      = addr_ff;
      cnt_in       = cnt_ff;
      pend_in      = 1'b0;
      mem_we       = 1'b0;
      mem_wdata    = '0;
      valid_in     = valid_ff;
      res_ack_in   = res_ack_ff;
      res_owner_in = res_owner_ff;
      res_mode_in  = res_mode_ff;
      res_kind_in  = res_kind_ff;
      res_chg_in   = res_chg_ff;

      unique case (state_ff)
         tdma_srt_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               rd_en        = slot_ok && (req_type != tdma_srt_pkg::TYPE_RELEASE);
               addr_in      = req_slot[IW-1:0];
               cnt_in       = '0;
               res_ack_in   = tdma_srt_pkg::ACK_NOP;
               res_owner_in = '0;
               res_mode_in  = tdma_srt_pkg::MODE_INVALID;
               res_kind_in  = tdma_srt_pkg::KIND_VACANT;
               res_chg_in   = 1'b0;
            end
         end

         tdma_srt_pkg::ST_EVAL: begin
            unique case (type_ff)
               tdma_srt_pkg::TYPE_REQUEST: begin
                  res_owner_in = cur.owner;
                  res_mode_in  = cur.mode;
                  res_kind_in  = cur.kind;
                  if (cmd_ff == tdma_srt_pkg::CMD_ALLOCATE) begin
                     if (cur.kind == tdma_srt_pkg::KIND_VACANT) begin
                        mem_we          = 1'b1;
                        mem_wdata.owner = peer_ff;
                        mem_wdata.mode  = (mode_ff == tdma_srt_pkg::MODE_SEND) ?
                                          tdma_srt_pkg::MODE_RECV : tdma_srt_pkg::MODE_SEND;
                        mem_wdata.kind  = kind_ff;
                        res_ack_in      = tdma_srt_pkg::ACK_APPROVE;
                        res_owner_in    = mem_wdata.owner;
                        res_mode_in     = mem_wdata.mode;
                        res_kind_in     = mem_wdata.kind;
                        res_chg_in      = 1'b1;
                     end else begin
                        res_ack_in = tdma_srt_pkg::ACK_DENIAL;
                     end
                  end else if (cmd_ff == tdma_srt_pkg::CMD_RELEASE) begin
                     if (owner_hit) begin
                        valid_in[addr_ff] = 1'b0;
                        res_ack_in        = tdma_srt_pkg::ACK_APPROVE;
                        res_mode_in       = tdma_srt_pkg::MODE_INVALID;
                        res_kind_in       = tdma_srt_pkg::KIND_VACANT;
                        res_chg_in        = 1'b1;
                     end else begin
                        res_ack_in = tdma_srt_pkg::ACK_DENIAL;
                     end
                  end
               end
               tdma_srt_pkg::TYPE_ACK: begin
                  if (cmd_ff == tdma_srt_pkg::CMD_ALLOCATE) begin
                     if (cur.kind == tdma_srt_pkg::KIND_PREORDAINED) begin
                        if (ack_ff == tdma_srt_pkg::ACK_APPROVE) begin
                           mem_we          = 1'b1;
                           mem_wdata.owner = peer_ff;
                           mem_wdata.mode  = mode_ff;
                           mem_wdata.kind  = kind_ff;
                           res_chg_in      = 1'b1;
                        end else if (ack_ff == tdma_srt_pkg::ACK_DENIAL) begin
                           valid_in[addr_ff] = 1'b0;
                           res_chg_in        = 1'b1;
                        end
                     end
                  end else if (cmd_ff == tdma_srt_pkg::CMD_RELEASE) begin
                     if (ack_ff == tdma_srt_pkg::ACK_APPROVE && owner_hit) begin
                        valid_in[addr_ff] = 1'b0;
                        res_chg_in        = 1'b1;
                     end
                  end
               end
               tdma_srt_pkg::TYPE_EXPIRE: begin
                  if (cmd_ff != tdma_srt_pkg::CMD_MAINTAIN &&
                      cur.kind == tdma_srt_pkg::KIND_PREORDAINED) begin
                     valid_in[addr_ff] = 1'b0;
                     res_chg_in        = 1'b1;
                  end
               end
               default: ;
            endcase
         end

         tdma_srt_pkg::ST_SCAN: begin
            // read slot cnt this cycle, compare the slot read last cycle
            rd_addr = cnt_ff[IW-1:0];
            if (cnt_ff != CW'(tdma_srt_pkg::SLOT_COUNT)) begin
               rd_en   = 1'b1;
               pend_in = 1'b1;
               addr_in = cnt_ff[IW-1:0];
               cnt_in  = cnt_ff + CW'(1);
            end
            if (pend_ff && owner_hit) begin
               valid_in[addr_ff] = 1'b0;
               res_chg_in        = 1'b1;
            end
         end

         tdma_srt_pkg::ST_DONE: ;
         default: ;
      endcase

      // a written entry becomes valid
      if (mem_we) begin
         valid_in[addr_ff] = 1'b1;
      end
   end

   assign rsp_valid_in = out_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tdma_srt_pkg::ST_IDLE;
         valid_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff      <= addr_in;
      cnt_ff       <= cnt_in;
      res_ack_ff   <= res_ack_in;
      res_owner_ff <= res_owner_in;
      res_mode_ff  <= res_mode_in;
      res_kind_ff  <= res_kind_in;
      res_chg_ff   <= res_chg_in;
      if (accept) begin
         type_ff <= req_type;
         peer_ff <= req_peer_id;
         cmd_ff  <= req_command;
         mode_ff <= req_link_mode;
         kind_ff <= req_link_kind;
         ack_ff  <= req_ack_code;
      end
      if (out_load) begin
         out_ack_ff   <= res_ack_ff;
         out_owner_ff <= res_owner_ff;
         out_mode_ff  <= res_mode_ff;
         out_kind_ff  <= res_kind_ff;
         out_chg_ff   <= res_chg_ff;
      end
   end

   // slot memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[addr_ff] <= mem_wdata;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_reply_ack   = out_ack_ff;
   assign rsp_reply_owner = out_owner_ff;
   assign rsp_reply_mode  = out_mode_ff;
   assign rsp_reply_kind  = out_kind_ff;
   assign rsp_changed     = out_chg_ff;

endmodule
